// File: rtl/shm_pkg.sv
// ----------------------------------------------------------------------------
// shm_pkg: SHA-256 hasher shared types and constants
// Holds the round constants, the initial hash and the word transaction type.
// ----------------------------------------------------------------------------
package shm_pkg;

	typedef struct packed {
		logic        last_blk;
		logic [31:0] word;
	} shm_word_t;

	localparam logic [31:0] INIT_HASH [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [31:0] ROUND_K [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [7:0] PAD_MARK = 8'h80;

endpackage

// File: rtl/sha256_message_hasher.sv
// ----------------------------------------------------------------------------
// sha256_message_hasher: SHA-256 over a byte stream
// At most one byte per transaction (byte_present); an end mark pads the message and emits the digest.
// ----------------------------------------------------------------------------
// Throughput: one byte per cycle while the packer is taking bytes and the word
// queue has room; each 64-byte block then holds the compressor while it loads
// sixteen words, runs 64 rounds and adds into the hash, so the single round
// unit sets the sustained rate.
// Reset: arst_n clears all control state and loads the initial hash.
module sha256_message_hasher #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  msg_byte,
	input  logic        byte_present,
	input  logic        end_of_message,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] digest_word,
	output logic [2:0]  word_index,
	output logic        last_word
);

	shm_pkg::shm_word_t push_data, pop_data;
	logic push_valid, push_ready, pop_valid, pop_ready;

	// front: pack bytes into words, generate padding and the length
	shm_front u_front (
		.clk, .arst_n, .in_valid, .in_ready, .msg_byte, .byte_present,
		.end_of_message, .push_valid, .push_ready, .push_data
	);

	// queue: decouple the packer from the compressor
	shm_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk, .arst_n,
		.wr_valid(push_valid), .wr_ready(push_ready), .wr_data(push_data),
		.rd_valid(pop_valid), .rd_ready(pop_ready), .rd_data(pop_data)
	);

	// back: compress blocks and hold the digest until each word is taken
	shm_back u_back (
		.clk, .arst_n, .pop_valid, .pop_ready, .pop_data,
		.out_valid, .out_ready, .digest_word, .word_index, .last_word
	);

endmodule

// File: rtl/shm_front.sv
// ----------------------------------------------------------------------------
// shm_front: byte packer and padder
// Packs bytes big-endian into words and appends padding and bit length.
// ----------------------------------------------------------------------------
module shm_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        msg_byte,
	input  logic              byte_present,
	input  logic              end_of_message,
	output logic              push_valid,
	input  logic              push_ready,
	output shm_pkg::shm_word_t push_data
);

	typedef enum logic [2:0] {
		ST_BYTES, ST_PAD_FIRST, ST_PAD_ZERO, ST_LEN_HI, ST_LEN_LO
	} state_t;

	state_t      state_q;
	logic [23:0] acc_q;
	logic [1:0]  pos_q;
	logic [3:0]  widx_q;
	logic [60:0] count_q;
	logic        take;
	logic [31:0] first_word;

	assign in_ready = (state_q == ST_BYTES) && push_ready;
	assign take     = in_valid && in_ready;

	always_comb begin
		unique case (pos_q)
			2'd0:    first_word = {shm_pkg::PAD_MARK, 24'h0};
			2'd1:    first_word = {acc_q[7:0], shm_pkg::PAD_MARK, 16'h0};
			2'd2:    first_word = {acc_q[15:0], shm_pkg::PAD_MARK, 8'h0};
			default: first_word = {acc_q[23:0], shm_pkg::PAD_MARK};
		endcase
	end

	always_comb begin
		push_data.last_blk = 1'b0;
		push_data.word     = 32'h0;
		push_valid         = 1'b0;
		unique case (state_q)
			ST_BYTES: begin
				push_valid     = take && byte_present && (pos_q == 2'd3);
				push_data.word = {acc_q, msg_byte};
			end
			ST_PAD_FIRST: begin
				push_valid     = 1'b1;
				push_data.word = first_word;
			end
			ST_PAD_ZERO: begin
				push_valid = 1'b1;
			end
			ST_LEN_HI: begin
				push_valid     = 1'b1;
				push_data.word = count_q[60:29];
			end
			default: begin
				push_valid         = 1'b1;
				push_data.word     = {count_q[28:0], 3'b000};
				push_data.last_blk = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_BYTES;
			pos_q   <= 2'd0;
			widx_q  <= 4'd0;
			count_q <= '0;
			acc_q   <= '0;
		end else begin
			if (push_valid && push_ready) widx_q <= widx_q + 4'd1;
			unique case (state_q)
				ST_BYTES: if (take) begin
					if (byte_present) begin
						acc_q   <= {acc_q[15:0], msg_byte};
						pos_q   <= pos_q + 2'd1;
						count_q <= count_q + 61'd1;
					end
					if (end_of_message) state_q <= ST_PAD_FIRST;
				end
				ST_PAD_FIRST: if (push_ready)
					state_q <= (widx_q == 4'd13) ? ST_LEN_HI : ST_PAD_ZERO;
				ST_PAD_ZERO: if (push_ready && widx_q == 4'd13) state_q <= ST_LEN_HI;
				ST_LEN_HI: if (push_ready) state_q <= ST_LEN_LO;
				default: if (push_ready) begin
					state_q <= ST_BYTES;
					pos_q   <= 2'd0;
					count_q <= '0;
				end
			endcase
		end
	end

endmodule

// File: rtl/shm_queue.sv
// ----------------------------------------------------------------------------
// shm_queue: word queue
// Small first-in first-out queue between the packer and the compressor.
// ----------------------------------------------------------------------------
module shm_queue #(
	parameter int DEPTH = 4
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_valid,
	output logic               wr_ready,
	input  shm_pkg::shm_word_t wr_data,
	output logic               rd_valid,
	input  logic               rd_ready,
	output shm_pkg::shm_word_t rd_data
);

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	shm_pkg::shm_word_t mem_q [DEPTH];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic          wr, rd;

	assign wr_ready = (cnt_q != AW'(0) + (AW+1)'(DEPTH));
	assign rd_valid = (cnt_q != '0);
	assign rd_data  = mem_q[rp_q];
	assign wr       = wr_valid && wr_ready;
	assign rd       = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(DEPTH - 1)) ? '0 : wp_q + AW'(1);
			if (rd) rp_q <= (rp_q == AW'(DEPTH - 1)) ? '0 : rp_q + AW'(1);
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end

endmodule

// File: rtl/shm_back.sv
// ----------------------------------------------------------------------------
// shm_back: compression engine
// Loads sixteen words, runs one round a cycle and emits the digest.
// ----------------------------------------------------------------------------
module shm_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pop_valid,
	output logic               pop_ready,
	input  shm_pkg::shm_word_t pop_data,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [31:0]        digest_word,
	output logic [2:0]         word_index,
	output logic               last_word
);

	typedef enum logic [1:0] {ST_LOAD, ST_ROUND, ST_ADD, ST_OUT} state_t;

	state_t      state_q;
	logic [31:0] w_q [16];
	logic [31:0] v_q [8];
	logic [31:0] h_q [8];
	logic [5:0]  cnt_q;
	logic        fin_q;
	logic [31:0] s0, s1, wnew, t1, t2, ch, maj, b1, b0;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

	assign pop_ready   = (state_q == ST_LOAD);
	assign out_valid   = (state_q == ST_OUT);
	assign word_index  = cnt_q[2:0];
	assign digest_word = h_q[cnt_q[2:0]];
	assign last_word   = (cnt_q[2:0] == 3'd7);

	always_comb begin
		s0   = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1   = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		wnew = w_q[0] + s0 + w_q[9] + s1;
		b1   = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		ch   = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1   = v_q[7] + b1 + ch + shm_pkg::ROUND_K[cnt_q] + w_q[0];
		b0   = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		maj  = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2   = b0 + maj;
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && pop_valid) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= pop_data.word;
		end else if (state_q == ST_ROUND) begin
			for (int j = 0; j < 15; j++) w_q[j] <= w_q[j+1];
			w_q[15] <= wnew;
		end
		if (state_q == ST_LOAD) begin
			v_q <= h_q;
		end else if (state_q == ST_ROUND) begin
			v_q[7] <= v_q[6];
			v_q[6] <= v_q[5];
			v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2];
			v_q[2] <= v_q[1];
			v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			fin_q   <= 1'b0;
			h_q     <= shm_pkg::INIT_HASH;
		end else begin
			unique case (state_q)
				ST_LOAD: if (pop_valid) begin
					cnt_q <= (cnt_q[3:0] == 4'd15) ? 6'd0 : cnt_q + 6'd1;
					if (cnt_q[3:0] == 4'd15) begin
						fin_q   <= pop_data.last_blk;
						state_q <= ST_ROUND;
					end
				end
				ST_ROUND: begin
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) state_q <= ST_ADD;
				end
				ST_ADD: begin
					for (int j = 0; j < 8; j++) h_q[j] <= h_q[j] + v_q[j];
					cnt_q   <= '0;
					state_q <= fin_q ? ST_OUT : ST_LOAD;
				end
				default: if (out_ready) begin
					if (cnt_q[2:0] == 3'd7) begin
						h_q     <= shm_pkg::INIT_HASH;
						cnt_q   <= '0;
						state_q <= ST_LOAD;
					end else begin
						cnt_q <= cnt_q + 6'd1;
					end
				end
			endcase
		end
	end

endmodule
